FILE: sv/vfa_pkg.sv
// Shared widths, operation and status codes, and saturation helper for the vector ALU.
package vfa_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int W           = 32;
    localparam int PROD_W      = 2 * W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int TOT_W       = PROD_W + 2;
    localparam int WIDE_W      = PROD_W + 4;
    localparam int DIV_W       = W + FRAC_BITS;
    localparam int REM_W       = W + 1;
    localparam int RAD_W       = 2 * W - 2;
    localparam int ROOT_W      = W - 1;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int TOL_W       = 16;
    localparam int LANES       = 4;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_NEG   = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_DOT   = 4'd5;
    localparam logic [3:0] OP_CROSS = 4'd6;
    localparam logic [3:0] OP_MAG   = 4'd7;
    localparam logic [3:0] OP_NORM  = 4'd8;
    localparam logic [3:0] OP_EQUAL = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0] val;
        logic         sat;
    } sat_t;

    typedef struct packed {
        logic [3:0]                op;
        logic [LANES-1:0][W-1:0]   vec;
        logic                      vsat;
        logic [W-1:0]              dot;
        logic                      dsat;
        logic                      eq;
        logic                      big;
        logic [LANES-1:0][W-1:0]   a;
        logic [W-1:0]              s;
    } side_t;

    typedef struct packed {
        side_t               side;
        logic [ROOT_W-1:0]   root;
    } tail_t;

    function automatic sat_t sat_w(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.sat = 1'b1;
        if (v > $signed({{(WIDE_W-W+1){1'b0}}, {(W-1){1'b1}}}))
        begin
            r.val = POS_MAX;
        end
        else if (v < $signed({{(WIDE_W-W+1){1'b1}}, {(W-1){1'b0}}}))
        begin
            r.val = NEG_MIN;
        end
        else
        begin
            r.val = v[W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/vec4_fixed_point_alu.sv
// Top level of the four-lane fixed-point vector ALU: lanes, reduction, root, divide and merge.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  command   | start / busy       | operation, a_x..a_w, b_x..b_w, scalar_in
//  result    | done (one cycle)   | r_x, r_y, r_z, r_w, r_scalar, r_equal, status
//  config    | cfg_we             | cfg_wdata (equal tolerance)
//
// One transaction per cycle; busy is always low. The delay is set by the 31-stage square
// root followed by the one-bit-per-stage divider. Reset clears the valid pipeline and sets
// the tolerance to 7.
// The receiver cannot stall: done pulses for one cycle with the result.
module vec4_fixed_point_alu
    import vfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic [TOL_W-1:0]    cfg_wdata,
    input  logic [3:0]          operation,
    input  logic signed [W-1:0] a_x,
    input  logic signed [W-1:0] a_y,
    input  logic signed [W-1:0] a_z,
    input  logic signed [W-1:0] a_w,
    input  logic signed [W-1:0] b_x,
    input  logic signed [W-1:0] b_y,
    input  logic signed [W-1:0] b_z,
    input  logic signed [W-1:0] b_w,
    input  logic signed [W-1:0] scalar_in,
    output logic                done,
    output logic signed [W-1:0] r_x,
    output logic signed [W-1:0] r_y,
    output logic signed [W-1:0] r_z,
    output logic signed [W-1:0] r_w,
    output logic signed [W-1:0] r_scalar,
    output logic                r_equal,
    output logic [1:0]          status
);

    logic [TOL_W-1:0] tol_reg;

    logic                     v1_reg;
    logic [3:0]               op1_reg;
    logic signed [W-1:0]      a1_reg [LANES];
    logic signed [W-1:0]      b1_reg [LANES];
    logic signed [W-1:0]      s1_reg;

    logic signed [W-1:0]      x0 [LANES];
    logic signed [W-1:0]      y0 [LANES];
    logic signed [W-1:0]      x1 [LANES];
    logic signed [W-1:0]      y1 [LANES];
    logic signed [PROD_W-1:0] p0 [LANES];
    logic signed [PROD_W-1:0] p1 [LANES];
    logic [W-1:0]             el [LANES];
    logic [LANES-1:0]         el_sat;
    logic [LANES-1:0]         el_eq;

    logic                     v2_reg;
    logic [3:0]               op2_reg;
    logic [W-1:0]             a2_reg [LANES];
    logic [W-1:0]             s2_reg;

    logic                     v3_reg;
    logic [3:0]               op3_reg;
    logic signed [SUM_W-1:0]  q3_reg [LANES];
    logic signed [SUM_W-1:0]  pr01_reg;
    logic signed [SUM_W-1:0]  pr23_reg;
    logic [W-1:0]             el3_reg [LANES];
    logic                     esat3_reg;
    logic                     eq3_reg;
    logic [W-1:0]             a3_reg [LANES];
    logic [W-1:0]             s3_reg;

    logic signed [TOT_W-1:0]  tot;
    sat_t                     dot_s;
    sat_t                     vs [LANES];
    side_t                    side4;
    logic                     v4_reg;
    side_t                    side4_reg;
    logic [RAD_W-1:0]         rad4_reg;

    logic                     sq_v;
    logic [ROOT_W-1:0]        sq_root;
    side_t                    sq_side;
    tail_t                    tail_in;

    logic [DIV_W-1:0]         dvd [LANES];
    logic [W-1:0]             dvs [LANES];
    logic [LANES-1:0]         dneg;
    logic [W-1:0]             dq [LANES];
    logic [LANES-1:0]         dsat;

    tail_t                    tail_reg [DIV_W];
    logic [DIV_W-1:0]         tail_v_reg;
    tail_t                    tf;
    logic [W-1:0]             rs_mag;

    logic [W-1:0]             rv [LANES];
    logic [W-1:0]             rsc;
    logic                     req;
    logic [1:0]               rst_code;

    logic                     done_reg;
    logic [W-1:0]             rx_reg;
    logic [W-1:0]             ry_reg;
    logic [W-1:0]             rz_reg;
    logic [W-1:0]             rw_reg;
    logic [W-1:0]             rs_reg;
    logic                     req_reg;
    logic [1:0]               status_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            tail_v_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            v1_reg     <= start && !busy;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            tail_v_reg <= {tail_v_reg[DIV_W-2:0], sq_v};
            done_reg   <= tail_v_reg[DIV_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= operation;
        a1_reg[0] <= a_x;
        a1_reg[1] <= a_y;
        a1_reg[2] <= a_z;
        a1_reg[3] <= a_w;
        b1_reg[0] <= b_x;
        b1_reg[1] <= b_y;
        b1_reg[2] <= b_z;
        b1_reg[3] <= b_w;
        s1_reg    <= scalar_in;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        logic is_cross;

        assign is_cross = (op1_reg == OP_CROSS) && (i < 3);

        always_comb
        begin
            x1[i] = is_cross ? a1_reg[I2] : '0;
            y1[i] = is_cross ? b1_reg[I1] : '0;
            if (op1_reg == OP_CROSS)
            begin
                x0[i] = is_cross ? a1_reg[I1] : '0;
                y0[i] = is_cross ? b1_reg[I2] : '0;
            end
            else
            begin
                x0[i] = a1_reg[i];
                if (op1_reg == OP_SCALE)
                begin
                    y0[i] = s1_reg;
                end
                else if (op1_reg == OP_DOT)
                begin
                    y0[i] = b1_reg[i];
                end
                else if (op1_reg == OP_MAG || op1_reg == OP_NORM)
                begin
                    y0[i] = a1_reg[i];
                end
                else
                begin
                    y0[i] = '0;
                end
            end
        end

        vfa_lane_mul u_mul (
            .clk      (clk),
            .op       (op1_reg),
            .a        (a1_reg[i]),
            .b        (b1_reg[i]),
            .x0       (x0[i]),
            .y0       (y0[i]),
            .x1       (x1[i]),
            .y1       (y1[i]),
            .tol      (tol_reg),
            .prod0    (p0[i]),
            .prod1    (p1[i]),
            .elem     (el[i]),
            .elem_sat (el_sat[i]),
            .elem_eq  (el_eq[i])
        );

        always_ff @(posedge clk)
        begin
            a2_reg[i]  <= a1_reg[i];
            q3_reg[i]  <= SUM_W'(p0[i]) - SUM_W'(p1[i]);
            el3_reg[i] <= el[i];
            a3_reg[i]  <= a2_reg[i];
        end

        assign vs[i] = sat_w(WIDE_W'(q3_reg[i] >>> FRAC_BITS));

        assign dneg[i] = (sq_side.op == OP_DIV) ? sq_side.a[i][W-1] ^ sq_side.s[W-1]
                                                : sq_side.a[i][W-1];
        assign dvd[i]  = {(sq_side.a[i][W-1] ? W'(0) - sq_side.a[i] : sq_side.a[i]),
                          {FRAC_BITS{1'b0}}};

        always_comb
        begin
            if (sq_side.op == OP_DIV)
            begin
                dvs[i] = sq_side.s[W-1] ? W'(0) - sq_side.s : sq_side.s;
            end
            else
            begin
                dvs[i] = sq_side.big ? POS_MAX : W'(sq_root);
            end
        end

        vfa_lane_div u_div (
            .clk      (clk),
            .dividend (dvd[i]),
            .divisor  (dvs[i]),
            .neg      (dneg[i]),
            .quo      (dq[i]),
            .sat      (dsat[i])
        );
    end

    always_ff @(posedge clk)
    begin
        op2_reg   <= op1_reg;
        s2_reg    <= s1_reg;
        op3_reg   <= op2_reg;
        s3_reg    <= s2_reg;
        pr01_reg  <= SUM_W'(p0[0]) + SUM_W'(p0[1]);
        pr23_reg  <= SUM_W'(p0[2]) + SUM_W'(p0[3]);
        esat3_reg <= |el_sat;
        eq3_reg   <= &el_eq;
    end

    assign tot   = TOT_W'(pr01_reg) + TOT_W'(pr23_reg);
    assign dot_s = sat_w(WIDE_W'(tot >>> FRAC_BITS));

    always_comb
    begin
        side4.op   = op3_reg;
        side4.dot  = dot_s.val;
        side4.dsat = dot_s.sat;
        side4.eq   = eq3_reg;
        side4.big  = tot[TOT_W-1:RAD_W] != '0;
        side4.s    = s3_reg;
        side4.vsat = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            side4.a[i]   = a3_reg[i];
            side4.vec[i] = '0;
        end
        if (op3_reg == OP_ADD || op3_reg == OP_SUB || op3_reg == OP_NEG)
        begin
            side4.vsat = esat3_reg;
            for (int i = 0; i < LANES; i++)
            begin
                side4.vec[i] = el3_reg[i];
            end
        end
        else if (op3_reg == OP_SCALE || op3_reg == OP_CROSS)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                side4.vec[i] = vs[i].val;
                side4.vsat   = side4.vsat | vs[i].sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side4_reg <= side4;
        rad4_reg  <= tot[RAD_W-1:0];
    end

    vfa_isqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .rad       (rad4_reg),
        .in_side   (side4_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    assign tail_in.side = sq_side;
    assign tail_in.root = sq_root;

    always_ff @(posedge clk)
    begin
        tail_reg[0] <= tail_in;
        for (int k = 1; k < DIV_W; k++)
        begin
            tail_reg[k] <= tail_reg[k-1];
        end
    end

    assign tf     = tail_reg[DIV_W-1];
    assign rs_mag = tf.side.big ? POS_MAX : W'(tf.root);

    always_comb
    begin
        rsc      = '0;
        req      = 1'b0;
        rst_code = ST_OK;
        for (int i = 0; i < LANES; i++)
        begin
            rv[i] = '0;
        end
        unique case (tf.side.op)
            OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    rv[i] = tf.side.vec[i];
                end
                rst_code = tf.side.vsat ? ST_SAT : ST_OK;
            end
            OP_DIV:
            begin
                if (tf.side.s == '0)
                begin
                    rst_code = ST_DIVZ;
                end
                else
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        rv[i] = dq[i];
                    end
                    rst_code = (|dsat) ? ST_SAT : ST_OK;
                end
            end
            OP_DOT:
            begin
                rsc      = tf.side.dot;
                rst_code = tf.side.dsat ? ST_SAT : ST_OK;
            end
            OP_MAG:
            begin
                rsc      = rs_mag;
                rst_code = tf.side.big ? ST_SAT : ST_OK;
            end
            OP_NORM:
            begin
                rsc = rs_mag;
                if (rs_mag == '0)
                begin
                    rst_code = ST_DIVZ;
                end
                else
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        rv[i] = dq[i];
                    end
                    rst_code = (tf.side.big || (|dsat)) ? ST_SAT : ST_OK;
                end
            end
            OP_EQUAL:
            begin
                req = tf.side.eq;
            end
            default:
            begin
                rsc = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rx_reg     <= rv[0];
        ry_reg     <= rv[1];
        rz_reg     <= rv[2];
        rw_reg     <= rv[3];
        rs_reg     <= rsc;
        req_reg    <= req;
        status_reg <= rst_code;
    end

    assign done     = done_reg;
    assign r_x      = rx_reg;
    assign r_y      = ry_reg;
    assign r_z      = rz_reg;
    assign r_w      = rw_reg;
    assign r_scalar = rs_reg;
    assign r_equal  = req_reg;
    assign status   = status_reg;

endmodule

FILE: sv/vfa_lane_mul.sv
// One vector lane: two signed multipliers and the element-wise add, subtract, negate and compare.
module vfa_lane_mul
    import vfa_pkg::*;
(
    input  logic                     clk,
    input  logic [3:0]               op,
    input  logic signed [W-1:0]      a,
    input  logic signed [W-1:0]      b,
    input  logic signed [W-1:0]      x0,
    input  logic signed [W-1:0]      y0,
    input  logic signed [W-1:0]      x1,
    input  logic signed [W-1:0]      y1,
    input  logic [TOL_W-1:0]         tol,
    output logic signed [PROD_W-1:0] prod0,
    output logic signed [PROD_W-1:0] prod1,
    output logic [W-1:0]             elem,
    output logic                     elem_sat,
    output logic                     elem_eq
);

    logic signed [W:0]         sum;
    logic signed [W:0]         diff;
    logic signed [W:0]         negv;
    logic [W:0]                adiff;
    logic signed [PROD_W-1:0]  p0;
    logic signed [PROD_W-1:0]  p1;
    sat_t                      es;
    logic signed [PROD_W-1:0]  prod0_reg;
    logic signed [PROD_W-1:0]  prod1_reg;
    logic [W-1:0]              elem_reg;
    logic                      elem_sat_reg;
    logic                      elem_eq_reg;

    always_comb
    begin
        sum   = (W+1)'(a) + (W+1)'(b);
        diff  = (W+1)'(a) - (W+1)'(b);
        negv  = (W+1)'(0) - (W+1)'(a);
        adiff = diff[W] ? (W+1)'(0) - diff : diff;
        p0    = x0 * y0;
        p1    = x1 * y1;
        unique case (op)
            OP_ADD:  es = sat_w(WIDE_W'(sum));
            OP_SUB:  es = sat_w(WIDE_W'(diff));
            OP_NEG:  es = sat_w(WIDE_W'(negv));
            default: es = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod0_reg    <= p0;
        prod1_reg    <= p1;
        elem_reg     <= es.val;
        elem_sat_reg <= es.sat;
        elem_eq_reg  <= (adiff <= (W+1)'(tol));
    end

    assign prod0    = prod0_reg;
    assign prod1    = prod1_reg;
    assign elem     = elem_reg;
    assign elem_sat = elem_sat_reg;
    assign elem_eq  = elem_eq_reg;

endmodule

FILE: sv/vfa_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband carried alongside.
module vfa_isqrt
    import vfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output side_t             out_side
);

    logic [RAD_W-1:0]       rem_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]       res_reg  [SQRT_STAGES];
    side_t                  side_reg [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] valid_reg;

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STAGES - 1 - j));
        logic [RAD_W-1:0] rem_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] trial;
        side_t            side_in;
        logic             valid_in;

        if (j == 0)
        begin : g_first
            assign rem_in   = rad;
            assign res_in   = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[j-1];
            assign res_in   = res_reg[j-1];
            assign side_in  = side_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge clk)
        begin
            side_reg[j] <= side_in;
            if (rem_in >= trial)
            begin
                rem_reg[j] <= rem_in - trial;
                res_reg[j] <= (res_in >> 1) + BIT;
            end
            else
            begin
                rem_reg[j] <= rem_in;
                res_reg[j] <= res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_in;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign root      = res_reg[SQRT_STAGES-1][ROOT_W-1:0];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

FILE: sv/vfa_lane_div.sv
// One lane of the pipelined restoring divider with signed saturating quotient.
module vfa_lane_div
    import vfa_pkg::*;
(
    input  logic              clk,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [W-1:0]      divisor,
    input  logic              neg,
    output logic [W-1:0]      quo,
    output logic              sat
);

    logic [REM_W-1:0] rem_reg [DIV_W];
    logic [DIV_W-1:0] num_reg [DIV_W];
    logic [DIV_W-1:0] q_reg   [DIV_W];
    logic [W-1:0]     d_reg   [DIV_W];
    logic [DIV_W-1:0] neg_reg;
    logic [DIV_W-1:0] qf;

    for (genvar j = 0; j < DIV_W; j++)
    begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [DIV_W-1:0] num_in;
        logic [DIV_W-1:0] q_in;
        logic [W-1:0]     d_in;
        logic             neg_in;
        logic [REM_W-1:0] shifted;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = dividend;
            assign q_in   = '0;
            assign d_in   = divisor;
            assign neg_in = neg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign d_in   = d_reg[j-1];
            assign neg_in = neg_reg[j-1];
        end

        assign shifted = {rem_in[W-1:0], num_in[DIV_W-1]};
        assign ge      = shifted >= REM_W'(d_in);

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? shifted - REM_W'(d_in) : shifted;
            num_reg[j] <= num_in << 1;
            q_reg[j]   <= {q_in[DIV_W-2:0], ge};
            d_reg[j]   <= d_in;
            neg_reg[j] <= neg_in;
        end
    end

    assign qf = q_reg[DIV_W-1];

    always_comb
    begin
        sat = 1'b0;
        if (neg_reg[DIV_W-1])
        begin
            if (qf > DIV_W'(NEG_MIN))
            begin
                quo = NEG_MIN;
                sat = 1'b1;
            end
            else
            begin
                quo = W'(0) - qf[W-1:0];
            end
        end
        else if (qf > DIV_W'(POS_MAX))
        begin
            quo = POS_MAX;
            sat = 1'b1;
        end
        else
        begin
            quo = qf[W-1:0];
        end
    end

endmodule

FILE: tb/vec4_fixed_point_alu_test.sv
// Self-checking testbench for the four-lane fixed-point vector ALU.
module vec4_fixed_point_alu_test;
    import vfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] a [4];
        logic signed [31:0] b [4];
        logic signed [31:0] s;
    } cmd_t;

    typedef struct {
        logic signed [31:0] v [4];
        logic signed [31:0] sc;
        logic               eq;
        logic [1:0]         st;
    } res_t;

    class alu_scoreboard;
        res_t             pending[$];
        logic [TOL_W-1:0] tol;
        int               mismatches;

        function new();
            tol = TOL_RESET;
            mismatches = 0;
        endfunction

        function automatic longint clamp(longint v, ref logic [1:0] st);
            if (v > 64'sd2147483647)
            begin
                st = ST_SAT;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                st = ST_SAT;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function automatic longint floor_q(logic signed [127:0] p);
            logic signed [127:0] q;
            q = p >>> FRAC_BITS;
            if (q > 128'sd4294967296)
                q = 128'sd4294967296;
            if (q < -128'sd4294967296)
                q = -128'sd4294967296;
            return longint'(q);
        endfunction

        function automatic longint root_floor(logic [63:0] x);
            logic [63:0] r;
            r = 0;
            for (int i = 31; i >= 0; i--)
                if ((r | (64'd1 << i)) * (r | (64'd1 << i)) <= x)
                    r = r | (64'd1 << i);
            return longint'(r);
        endfunction

        function automatic longint div_trunc(longint n, longint d);
            return n / d;
        endfunction

        function automatic void note(cmd_t c);
            res_t        e;
            logic [1:0]  st;
            longint      acc;
            logic [63:0] sum;
            logic [63:0] m;
            logic signed [127:0] p;
            bit          big;
            st = ST_OK;
            e.sc = 0;
            e.eq = 0;
            for (int i = 0; i < 4; i++)
                e.v[i] = 0;
            case (c.op)
                OP_ADD:
                    for (int i = 0; i < 4; i++)
                        e.v[i] = clamp(longint'(c.a[i]) + c.b[i], st);
                OP_SUB:
                    for (int i = 0; i < 4; i++)
                        e.v[i] = clamp(longint'(c.a[i]) - c.b[i], st);
                OP_NEG:
                    for (int i = 0; i < 4; i++)
                        e.v[i] = clamp(-longint'(c.a[i]), st);
                OP_SCALE:
                    for (int i = 0; i < 4; i++)
                        e.v[i] = clamp(floor_q(128'(longint'(c.a[i]) * c.s)), st);
                OP_DIV:
                    if (c.s == 0)
                        st = ST_DIVZ;
                    else
                        for (int i = 0; i < 4; i++)
                            e.v[i] = clamp(div_trunc(longint'(c.a[i]) <<< FRAC_BITS, c.s), st);
                OP_DOT:
                begin
                    p = 0;
                    for (int i = 0; i < 4; i++)
                        p += 128'(longint'(c.a[i]) * c.b[i]);
                    e.sc = clamp(floor_q(p), st);
                end
                OP_CROSS:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        p = 128'(longint'(c.a[(i+1)%3]) * c.b[(i+2)%3])
                            - 128'(longint'(c.a[(i+2)%3]) * c.b[(i+1)%3]);
                        e.v[i] = clamp(floor_q(p), st);
                    end
                end
                OP_MAG, OP_NORM:
                begin
                    sum = 0;
                    big = 0;
                    for (int i = 0; i < 4; i++)
                    begin
                        m = c.a[i] < 0 ? 64'(-longint'(c.a[i])) : 64'(longint'(c.a[i]));
                        if (!big)
                        begin
                            sum += m * m;
                            if (sum >= (64'd1 << 62))
                                big = 1;
                        end
                    end
                    if (big)
                    begin
                        acc = 64'sd2147483647;
                        st = ST_SAT;
                    end
                    else
                        acc = root_floor(sum);
                    e.sc = acc;
                    if (c.op == OP_NORM)
                    begin
                        if (acc == 0)
                            st = ST_DIVZ;
                        else
                            for (int i = 0; i < 4; i++)
                                e.v[i] = clamp(div_trunc(longint'(c.a[i]) <<< FRAC_BITS, acc), st);
                    end
                end
                OP_EQUAL:
                begin
                    e.eq = 1;
                    for (int i = 0; i < 4; i++)
                    begin
                        acc = longint'(c.a[i]) - c.b[i];
                        if (acc < 0)
                            acc = -acc;
                        if (acc > tol)
                            e.eq = 0;
                    end
                end
                default: ;
            endcase
            e.st = st;
            pending.push_back(e);
        endfunction

        function automatic void check(res_t got);
            res_t e;
            bit   bad;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sc=%h st=%0d", got.sc, got.st);
                return;
            end
            e = pending.pop_front();
            bad = (e.sc !== got.sc) || (e.eq !== got.eq) || (e.st !== got.st);
            for (int i = 0; i < 4; i++)
                if (e.v[i] !== got.v[i])
                    bad = 1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h %h %h %h sc=%h eq=%b st=%0d / got %h %h %h %h sc=%h eq=%b st=%0d",
                             e.v[0], e.v[1], e.v[2], e.v[3], e.sc, e.eq, e.st,
                             got.v[0], got.v[1], got.v[2], got.v[3], got.sc, got.eq, got.st);
            end
        endfunction
    endclass

    localparam int LATENCY = 4 + 31 + 32 + FRAC_BITS + 1;
    localparam int STALL_LIMIT = 20 * LATENCY + 100;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_we;
    logic [TOL_W-1:0] cfg_wdata;
    logic [3:0] operation;
    logic signed [W-1:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in;
    logic done;
    logic signed [W-1:0] r_x, r_y, r_z, r_w, r_scalar;
    logic r_equal;
    logic [1:0] status;

    alu_scoreboard vector_board;
    int idle_cycles;

    vec4_fixed_point_alu u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .operation(operation),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w), .scalar_in(scalar_in),
        .done(done), .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
        .r_scalar(r_scalar), .r_equal(r_equal), .status(status)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.v[0] = r_x;
                got.v[1] = r_y;
                got.v[2] = r_z;
                got.v[3] = r_w;
                got.sc = r_scalar;
                got.eq = r_equal;
                got.st = status;
                vector_board.check(got);
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 0;
            3: return $signed(32'($urandom_range(0, 15)) - 32'd8);
            4, 5: return $signed(32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send(cmd_t c);
        @(negedge clk);
        start <= 1'b1;
        operation <= c.op;
        a_x <= c.a[0]; a_y <= c.a[1]; a_z <= c.a[2]; a_w <= c.a[3];
        b_x <= c.b[0]; b_y <= c.b[1]; b_z <= c.b[2]; b_w <= c.b[3];
        scalar_in <= c.s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        vector_board.note(c);
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        pause(1);
        while (vector_board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        vector_board.tol = v;
    endtask

    function automatic cmd_t random_cmd(logic [3:0] op);
        cmd_t c;
        c.op = op;
        for (int i = 0; i < 4; i++)
        begin
            c.a[i] = pick_value();
            c.b[i] = ($urandom_range(0, 2) == 0) ? c.a[i] + $signed(32'($urandom_range(0, 20)) - 32'd10)
                                                : pick_value();
        end
        c.s = pick_value();
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        logic [TOL_W-1:0] tols [4];
        vector_board = new();
        idle_cycles = 0;
        rst_n = 0;
        start = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        operation = OP_ADD;
        {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in} = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        for (int op = 0; op < 16; op++)
        begin
            c.op = op;
            for (int i = 0; i < 4; i++)
            begin
                c.a[i] = (op % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
                c.b[i] = (op % 3) ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            c.s = (op == OP_DIV) ? 32'sd0 : 32'sh80000000;
            send(c);
        end
        for (int i = 0; i < 4; i++)
        begin
            c.a[i] = 0;
            c.b[i] = i;
        end
        c.op = OP_NORM;
        send(c);
        c.op = OP_EQUAL;
        send(c);
        c.a[0] = 32'sh0001_0000;
        c.s = 32'sh0000_0001;
        c.op = OP_DIV;
        send(c);
        c.op = OP_NORM;
        send(c);

        tols[0] = 16'hFFFF;
        tols[1] = 16'h0000;
        tols[2] = 16'h0100;
        tols[3] = TOL_RESET;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_tolerance(tols[ph]);
            for (int n = 0; n < 500; n++)
            begin
                send(random_cmd($urandom_range(0, 20) == 0 ? $urandom_range(10, 15)
                                                          : $urandom_range(0, 9)));
                if ($urandom_range(0, 3) == 0)
                    pause($urandom_range(0, 11));
            end
        end
        drain();
        if (vector_board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: sim.f
sv/vfa_pkg.sv
sv/vfa_lane_mul.sv
sv/vfa_isqrt.sv
sv/vfa_lane_div.sv
sv/vec4_fixed_point_alu.sv
tb/vec4_fixed_point_alu_test.sv
